/* rtl/spmf_pkg.sv */
// Shared types and constants for the strict priority multilevel FIFO.
// Used by spmf_ctrl, the top level and the port checker; no dependencies.
`default_nettype none

package spmf_pkg;

    localparam int ID_W      = 16;
    localparam int LVL_W     = 3;
    localparam int KIND_W    = 1;
    localparam int ST_W      = 2;
    localparam int TDATA_W   = 24;

    localparam logic [KIND_W-1:0] KIND_ENQ = 1'b0;
    localparam logic [KIND_W-1:0] KIND_DEQ = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_ENQ   = 2'd0,
        ST_DROP  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        status_t          status;
        logic [LVL_W-1:0] level;
    } ctrl_t;

endpackage

`default_nettype wire

/* rtl/spmf_store.sv */
// Identifier store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module spmf_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 16
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/spmf_ctrl.sv */
// Per-level head pointers and fill counts, full check and priority encoder.
// Depends on spmf_pkg for status codes and the control struct.
`default_nettype none

module spmf_ctrl #(
    parameter int NUM_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 8,
    parameter int AW          = 6
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        op_en,
    input  wire logic [spmf_pkg::KIND_W-1:0] kind,
    input  wire logic [spmf_pkg::LVL_W-1:0]  level,
    output spmf_pkg::ctrl_t                  ctl,
    output logic      [AW-1:0]               wr_addr,
    output logic      [AW-1:0]               rd_addr
);

    import spmf_pkg::*;

    localparam int LIW = $clog2(NUM_LEVELS);
    localparam int HW  = $clog2(LEVEL_DEPTH);
    localparam int FW  = $clog2(LEVEL_DEPTH + 1);

    logic [HW-1:0] head_reg [NUM_LEVELS];
    logic [FW-1:0] fill_reg [NUM_LEVELS];

    logic           is_enq;
    logic           lvl_in_range;
    logic           enq_ok;
    logic [LIW-1:0] enq_lvl;
    logic [HW:0]    slot_sum;
    logic [HW-1:0]  slot;
    logic           found;
    logic [LIW-1:0] deq_lvl;

    always_comb begin
        is_enq       = (kind == KIND_ENQ);
        lvl_in_range = (int'(level) < NUM_LEVELS);
        enq_lvl      = lvl_in_range ? LIW'(level) : '0;
        enq_ok       = lvl_in_range && (fill_reg[enq_lvl] != FW'(LEVEL_DEPTH));
        slot_sum     = {1'b0, head_reg[enq_lvl]} + (HW+1)'(fill_reg[enq_lvl]);
        if (slot_sum >= (HW+1)'(LEVEL_DEPTH)) begin
            slot = HW'(slot_sum - (HW+1)'(LEVEL_DEPTH));
        end else begin
            slot = slot_sum[HW-1:0];
        end
        wr_addr = AW'(enq_lvl * LEVEL_DEPTH) + AW'(slot);

        found   = 1'b0;
        deq_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (fill_reg[i] != '0) begin
                found   = 1'b1;
                deq_lvl = LIW'(i);
            end
        end
        rd_addr = AW'(deq_lvl * LEVEL_DEPTH) + AW'(head_reg[deq_lvl]);

        ctl.wr_en = op_en && is_enq && enq_ok;
        ctl.rd_en = op_en && !is_enq && found;
        if (is_enq) begin
            ctl.status = enq_ok ? ST_ENQ : ST_DROP;
            ctl.level  = '0;
        end else begin
            ctl.status = found ? ST_DEQ : ST_EMPTY;
            ctl.level  = found ? LVL_W'(deq_lvl) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            if (ctl.wr_en) begin
                fill_reg[enq_lvl] <= fill_reg[enq_lvl] + FW'(1);
            end
            if (ctl.rd_en) begin
                fill_reg[deq_lvl] <= fill_reg[deq_lvl] - FW'(1);
                if (head_reg[deq_lvl] == HW'(LEVEL_DEPTH - 1)) begin
                    head_reg[deq_lvl] <= '0;
                end else begin
                    head_reg[deq_lvl] <= head_reg[deq_lvl] + HW'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/strict_priority_multilevel_fifo_top.sv */
// Top level of the strict priority multilevel FIFO scheduler.
// Depends on spmf_pkg, spmf_ctrl and spmf_store.
//
// Each input transfer is an enqueue (id appended to its level's ring, or dropped when
// that level is full or out of range) or a dequeue (oldest id of the lowest-numbered
// non-empty level, or an all-empty status); each yields exactly one result transfer.
// A transfer is registered, resolved against the per-level head pointers and fill counts
// while the store is written or read, and delivered from the result register; one transfer
// per cycle is sustained while m_tready holds, set by the single pass through the priority
// encoder and the single read port of the store.
// The store needs no clearing after reset; only the head pointers, fill counts and valid flags are reset.
`default_nettype none

module strict_priority_multilevel_fifo_top #(
    parameter int NUM_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 8,
    parameter int ID_BITS     = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [spmf_pkg::TDATA_W-1:0] s_tdata,  // proc_id[15:0], level[18:16]
    input  wire logic [spmf_pkg::KIND_W-1:0]  s_tuser,  // kind[0]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [spmf_pkg::TDATA_W-1:0] m_tdata,  // out_id[15:0], out_level[18:16]
    output logic      [spmf_pkg::ST_W-1:0]    m_tuser   // status[1:0]
);

    import spmf_pkg::*;

    localparam int SB    = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic              in_valid_reg;
    logic [KIND_W-1:0] in_kind_reg;
    logic [SB-1:0]     in_id_reg;
    logic [LVL_W-1:0]  in_level_reg;

    logic              m_valid_reg;
    status_t           status_reg;
    logic [LVL_W-1:0]  level_reg;

    logic              adv;
    ctrl_t             ctl;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [SB-1:0]     rd_data;
    logic [ID_W-1:0]   out_id;

    assign adv      = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            in_kind_reg  <= s_tuser;
            in_id_reg    <= s_tdata[SB-1:0];
            in_level_reg <= s_tdata[ID_W +: LVL_W];
        end
        if (adv) begin
            status_reg <= ctl.status;
            level_reg  <= ctl.level;
        end
    end

    spmf_ctrl #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_en   (adv),
        .kind    (in_kind_reg),
        .level   (in_level_reg),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr)
    );

    spmf_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SB)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_id_reg),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_id   = (status_reg == ST_DEQ) ? ID_W'(rd_data) : '0;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {(TDATA_W - ID_W - LVL_W)'(0), level_reg, out_id};

endmodule

`default_nettype wire

/* rtl/spmf_checker.sv */
// Port-level checker for the strict priority multilevel FIFO, bound to the top level.
// Depends on spmf_pkg and strict_priority_multilevel_fifo_top.
`default_nettype none

module spmf_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [spmf_pkg::TDATA_W-1:0] m_tdata,
    input wire logic [spmf_pkg::ST_W-1:0]    m_tuser
);

    import spmf_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_zero_unless_deq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DEQ) |-> (m_tdata == '0))
        else $error("nonzero id or level on a result that is not a dequeue");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TDATA_W-1:ID_W+LVL_W] == '0))
        else $error("padding bits of result data not zero");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result transfer changed");

endmodule

bind strict_priority_multilevel_fifo_top spmf_checker u_spmf_checker (.*);

`default_nettype wire

/* verif/strict_priority_multilevel_fifo_top_test.sv */
// Self-checking testbench for strict_priority_multilevel_fifo_top: per-level ring scheduler
// checked transfer by transfer against an in-bench scoreboard model of the rings.
// Depends on spmf_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module strict_priority_multilevel_fifo_top_test;

    import spmf_pkg::*;

    localparam int NUM_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 8;
    localparam int ID_BITS     = 16;
    localparam int RAND_ITEMS  = 1700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   proc_id;
        logic [LVL_W-1:0]  level;
    } sched_item_t;

    typedef struct {
        status_t          status;
        logic [ID_W-1:0]  out_id;
        logic [LVL_W-1:0] out_level;
    } sched_result_t;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = KIND_ENQ;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [ST_W-1:0]      m_tuser;

    sched_item_t   pending_ops[$];
    sched_result_t sched_expected[$];
    sched_item_t   driver_op;
    sched_item_t   seen_op;
    sched_result_t want_res;

    logic [ID_W-1:0] ring_store [NUM_LEVELS][LEVEL_DEPTH];
    int              ring_head  [NUM_LEVELS];
    int              ring_fill  [NUM_LEVELS];

    int total_items = 0;
    int in_accepted = 0;
    int mismatches  = 0;
    int cycle_cnt   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int tx_idle_pct;
    int rx_idle_pct;

    strict_priority_multilevel_fifo_top #(
        .NUM_LEVELS (NUM_LEVELS),
        .LEVEL_DEPTH(LEVEL_DEPTH),
        .ID_BITS    (ID_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic sched_result_t schedule_predict(input sched_item_t it);
        sched_result_t r;
        int            slot;
        bit            found;
        r.status    = ST_ENQ;
        r.out_id    = '0;
        r.out_level = '0;
        found       = 1'b0;
        if (it.kind == KIND_ENQ) begin
            if (int'(it.level) >= NUM_LEVELS || ring_fill[it.level] >= LEVEL_DEPTH) begin
                r.status = ST_DROP;
            end else begin
                slot = (ring_head[it.level] + ring_fill[it.level]) % LEVEL_DEPTH;
                ring_store[it.level][slot] = it.proc_id;
                ring_fill[it.level] += 1;
            end
        end else begin
            r.status = ST_EMPTY;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (!found && ring_fill[l] > 0) begin
                    r.status    = ST_DEQ;
                    r.out_id    = ring_store[l][ring_head[l]];
                    r.out_level = LVL_W'(l);
                    ring_head[l] = (ring_head[l] + 1) % LEVEL_DEPTH;
                    ring_fill[l] -= 1;
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic add_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                          input logic [LVL_W-1:0] lvl);
        sched_item_t it;
        it.kind    = kind;
        it.proc_id = id;
        it.level   = lvl;
        pending_ops.push_back(it);
    endtask

    task automatic flag_mismatch(input string msg);
        if (mismatches < 10) begin
            $display("%s", msg);
        end
        mismatches++;
    endtask

    always_comb begin
        if (in_accepted < total_items / 3) begin
            tx_idle_pct = 8;
            rx_idle_pct = 77;
        end else if (in_accepted < (2 * total_items) / 3) begin
            tx_idle_pct = 77;
            rx_idle_pct = 8;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    // hold off the receiver once so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && in_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= KIND_ENQ;
        end else if (!s_tvalid || s_tready) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                driver_op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(TDATA_W - ID_W - LVL_W){1'b0}}, driver_op.level,
                             driver_op.proc_id};
                s_tuser  <= driver_op.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                seen_op.kind    = s_tuser;
                seen_op.proc_id = s_tdata[ID_W-1:0];
                seen_op.level   = s_tdata[ID_W +: LVL_W];
                sched_expected.push_back(schedule_predict(seen_op));
                in_accepted <= in_accepted + 1;
            end
            if (m_tvalid && m_tready) begin
                if (sched_expected.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result: status %0d id %h level %0d",
                                            m_tuser, m_tdata[ID_W-1:0],
                                            m_tdata[ID_W +: LVL_W]));
                end else begin
                    want_res = sched_expected.pop_front();
                    if (m_tuser !== want_res.status) begin
                        flag_mismatch($sformatf("status: expected %0d, got %0d",
                                                want_res.status, m_tuser));
                    end
                    if (m_tdata[ID_W-1:0] !== want_res.out_id) begin
                        flag_mismatch($sformatf("out_id: expected %h, got %h",
                                                want_res.out_id, m_tdata[ID_W-1:0]));
                    end
                    if (m_tdata[ID_W +: LVL_W] !== want_res.out_level) begin
                        flag_mismatch($sformatf("out_level: expected %0d, got %0d",
                                                want_res.out_level,
                                                m_tdata[ID_W +: LVL_W]));
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("strict_priority_multilevel_fifo_top: mismatch");
            $finish;
        end
    end

    initial begin
        int              n;
        int              burst;
        int              enq_pct;
        int              lvl_lo;
        int              lvl_hi;
        int              pick;
        logic [ID_W-1:0] id;

        for (int l = 0; l < NUM_LEVELS; l++) begin
            ring_head[l] = 0;
            ring_fill[l] = 0;
        end

        // dequeue with every level empty, then extremes of id and level
        add_op(KIND_DEQ, 16'hFFFF, 3'd7);
        add_op(KIND_ENQ, 16'hFFFF, 3'd7);
        add_op(KIND_ENQ, 16'h0000, 3'd0);
        add_op(KIND_DEQ, 16'h0000, 3'd0);
        add_op(KIND_DEQ, 16'h0000, 3'd0);
        add_op(KIND_DEQ, 16'h0000, 3'd0);
        // fill one level, then overflow it
        for (int k = 0; k < LEVEL_DEPTH + 1; k++) begin
            add_op(KIND_ENQ, ID_W'(16'h3000 + k), 3'd3);
        end
        add_op(KIND_ENQ, 16'hA5A5, 3'd5);
        add_op(KIND_ENQ, 16'h5A5A, 3'd1);
        for (int k = 0; k < 5; k++) begin
            add_op(KIND_DEQ, 16'h0000, 3'd0);
        end

        n = 0;
        while (n < RAND_ITEMS) begin
            pick = $urandom_range(0, 4);
            case (pick)
                0: enq_pct = 20;
                1: enq_pct = 45;
                2: enq_pct = 55;
                3: enq_pct = 80;
                default: enq_pct = 95;
            endcase
            lvl_lo = $urandom_range(0, NUM_LEVELS - 1);
            lvl_hi = $urandom_range(lvl_lo, NUM_LEVELS - 1);
            burst  = $urandom_range(20, 80);
            for (int j = 0; j < burst; j++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    id = '0;
                end else if (pick == 1) begin
                    id = '1;
                end else begin
                    id = ID_W'($urandom);
                end
                add_op(($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ, id,
                       LVL_W'($urandom_range(lvl_lo, lvl_hi)));
                n++;
            end
        end
        total_items = pending_ops.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (pending_ops.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (sched_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && sched_expected.size() == 0) begin
            $display("strict_priority_multilevel_fifo_top: match");
        end else begin
            $display("strict_priority_multilevel_fifo_top: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/spmf_pkg.sv
rtl/spmf_store.sv
rtl/spmf_ctrl.sv
rtl/strict_priority_multilevel_fifo_top.sv
rtl/spmf_checker.sv
verif/strict_priority_multilevel_fifo_top_test.sv
